[rtl/core/ilst_pkg.sv]
// Shared types and constants for the indexed list store.
`default_nettype none

package ilst_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W = 8;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned CMD_W = 3;

  // Default number of list entries.
  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_HEAD   = 3'd1,
    CMD_TAIL   = 3'd2,
    CMD_BEFORE = 3'd3,
    CMD_DELETE = 3'd4
  } command_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Shift controls broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_op_t;

endpackage

`default_nettype wire

[rtl/core/indexed_list_store.sv]
// Top level of the indexed list store: command decode, cell chain and result register.
// The list lives in a chain of CAPACITY cells, one entry per cell; an insert or delete
// shifts every cell above the position by one place at once, and a read picks
// the addressed cell through an OR bus. One command may be accepted on every clock
// while the input is not stalled. The single result of each command is held in
// an output register; the input is stalled only while that register holds a result that
// the downstream side has not yet taken. Entries are not cleared after reset, and no
// clearing pass is needed since positions at or beyond the length are never read.
`default_nettype none

module indexed_list_store #(
  parameter int unsigned CAPACITY = ilst_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ilst_pkg::CMD_W-1:0]    command,
  input  logic signed [ilst_pkg::POS_W-1:0]  position,
  input  logic signed [ilst_pkg::DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ilst_pkg::DATA_W-1:0] read_value,
  output logic                          read_valid,
  output logic [1:0]                    status,
  output logic [ilst_pkg::LEN_W-1:0]    length
);
  import ilst_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > (POS_W - 1)) ? CNT_W : (POS_W - 1);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              accept;
  logic              neg;
  logic [CMP_W-1:0]  mag_w;
  logic [CMP_W-1:0]  cnt_w;
  logic [CMP_W-1:0]  ins_p;
  logic              ins_req;
  logic              ins_go;
  logic              del_go;
  logic              rd_hit;
  status_t           st;
  logic [IDX_W-1:0]  pos;
  cell_op_t          op;
  logic [DATA_W-1:0] rd_or;

  logic [DATA_W-1:0] cell_q  [CAPACITY];
  logic [DATA_W-1:0] cell_rd [CAPACITY];

  assign accept = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  assign neg   = position[POS_W-1];
  assign mag_w = CMP_W'(position[POS_W-2:0]);
  assign cnt_w = CMP_W'(count);

  // Command decode: choose the operation, its position and the status.
  always_comb begin
    ins_req    = 1'b0;
    ins_p      = '0;
    ins_go     = 1'b0;
    del_go     = 1'b0;
    rd_hit     = 1'b0;
    st         = ST_DONE;
    pos        = '0;
    count_next = count;
    unique case (command)
      CMD_READ: begin
        if (!neg && (mag_w < cnt_w)) begin
          rd_hit = 1'b1;
          pos    = IDX_W'(mag_w);
        end else begin
          st = ST_BADPOS;
        end
      end
      CMD_HEAD: begin
        ins_req = 1'b1;
      end
      CMD_TAIL: begin
        ins_req = 1'b1;
        ins_p   = cnt_w;
      end
      CMD_BEFORE: begin
        ins_req = 1'b1;
        ins_p   = neg ? '0 : mag_w;
      end
      CMD_DELETE: begin
        if (!neg && (mag_w < cnt_w)) begin
          del_go     = 1'b1;
          pos        = IDX_W'(mag_w);
          count_next = count - CNT_W'(1);
        end else begin
          st = ST_BADPOS;
        end
      end
      default: begin
        st = ST_BADPOS;
      end
    endcase
    // The position test comes before the full test.
    if (ins_req) begin
      if (ins_p > cnt_w) begin
        st = ST_BADPOS;
      end else if (count == CNT_W'(CAPACITY)) begin
        st = ST_FULL;
      end else begin
        ins_go     = 1'b1;
        pos        = IDX_W'(ins_p);
        count_next = count + CNT_W'(1);
      end
    end
  end

  assign op.ins = ins_go && accept;
  assign op.del = del_go && accept;

  // Chain of cells; each takes its neighbour's entry when the list shifts.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_q[i+1];
    end
    ilst_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .pos       (pos),
      .new_value (value),
      .lower     (lower),
      .upper     (upper),
      .q         (cell_q[i]),
      .rd        (cell_rd[i])
    );
  end

  // Read bus: only the addressed cell drives non-zero bits.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // Length register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register; a new transfer loads it whenever the old result is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value <= rd_hit ? rd_or : '1;
      read_valid <= rd_hit;
      status     <= st;
      length     <= LEN_W'(count_next);
    end
  end

  // The length never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  // A successful insert grows the list by exactly one entry.
  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    op.ins |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list by one");

  // A rejected insert for lack of room only happens on a full list.
  a_full_only: assert property (@(posedge clk) disable iff (rst)
    accept && (st == ST_FULL) |-> count == CNT_W'(CAPACITY))
    else $error("full status on a list with room");

  // A valid read always reports success.
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> status == ST_DONE)
    else $error("valid read with failure status");

  // Insert and delete never act together on the chain.
  a_op_excl: assert property (@(posedge clk) disable iff (rst)
    !(op.ins && op.del))
    else $error("insert and delete in the same cycle");

endmodule

`default_nettype wire

[rtl/core/ilst_cell.sv]
// One storage cell of the list chain, holding the entry at a fixed position.
`default_nettype none

module ilst_cell #(
  parameter int unsigned IDX_W = 6,
  parameter int unsigned INDEX = 0
) (
  input  logic                         clk,
  input  ilst_pkg::cell_op_t           op,
  input  logic [IDX_W-1:0]             pos,
  input  logic [ilst_pkg::DATA_W-1:0]  new_value,
  input  logic [ilst_pkg::DATA_W-1:0]  lower,
  input  logic [ilst_pkg::DATA_W-1:0]  upper,
  output logic [ilst_pkg::DATA_W-1:0]  q,
  output logic [ilst_pkg::DATA_W-1:0]  rd
);
  import ilst_pkg::*;

  logic [IDX_W-1:0] my_index;
  logic             at_pos;
  logic             above_pos;

  assign my_index  = IDX_W'(INDEX);
  assign at_pos    = (my_index == pos);
  assign above_pos = (my_index > pos);

  // Insert moves entries above the position up one place; delete moves them down.
  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (above_pos) begin
        q <= lower;
      end else if (at_pos) begin
        q <= new_value;
      end
    end else if (op.del) begin
      if (above_pos || at_pos) begin
        q <= upper;
      end
    end
  end

  // The selected cell drives its entry onto the read OR bus.
  assign rd = at_pos ? q : '0;

endmodule

`default_nettype wire

[sim/list_checker.sv]
// Transfer monitor, list predictor and result comparison for the indexed list store.
`default_nettype none

module list_checker #(
  parameter int unsigned CAPACITY = ilst_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [ilst_pkg::CMD_W-1:0]         command,
  input  logic signed [ilst_pkg::POS_W-1:0]  position,
  input  logic signed [ilst_pkg::DATA_W-1:0] value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [ilst_pkg::DATA_W-1:0] read_value,
  input  logic                               read_valid,
  input  logic [1:0]                         status,
  input  logic [ilst_pkg::LEN_W-1:0]         length,
  output int                                 fail_count,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ilst_pkg::*;

  localparam int unsigned SHOWN_MAX = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] rd;
    logic                     ok;
    status_t                  st;
    logic [LEN_W-1:0]         len;
  } list_result_t;

  // Our own copy of the list contents and its length.
  logic [DATA_W-1:0] list_vals [CAPACITY];
  int                list_len;
  list_result_t      awaited [$];

  // Put a value at place p, moving later entries up by one place.
  function automatic status_t place_value(int p, logic [DATA_W-1:0] v);
    if (p > list_len) return ST_BADPOS;
    if (list_len >= int'(CAPACITY)) return ST_FULL;
    for (int i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
    list_vals[p] = v;
    list_len++;
    return ST_DONE;
  endfunction

  // Work out the single result of one command and update the list.
  function automatic list_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                 logic signed [POS_W-1:0] pos,
                                                 logic [DATA_W-1:0] val);
    list_result_t r;
    int           p;
    p    = int'(pos);
    r.rd = -1;
    r.ok = 1'b0;
    r.st = ST_DONE;
    case (cmd)
      CMD_READ: begin
        if (p >= 0 && p < list_len) begin
          r.rd = list_vals[p];
          r.ok = 1'b1;
        end else begin
          r.st = ST_BADPOS;
        end
      end
      CMD_HEAD:   r.st = place_value(0, val);
      CMD_TAIL:   r.st = place_value(list_len, val);
      // A negative place is clamped to the head.
      CMD_BEFORE: r.st = place_value((p < 0) ? 0 : p, val);
      CMD_DELETE: begin
        if (p >= 0 && p < list_len) begin
          for (int i = p; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end else begin
          r.st = ST_BADPOS;
        end
      end
      default: r.st = ST_BADPOS;
    endcase
    r.len = list_len[LEN_W-1:0];
    return r;
  endfunction

  // Compare each result transfer with the oldest expectation, then record
  // the expectation of any command accepted at the same edge.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len = 0;
      awaited.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_MAX)
            $display("%0t: result with nothing expected: value %0d valid %0b status %0d len %0d",
                     $realtime, read_value, read_valid, status, length);
        end else begin
          want = awaited.pop_front();
          if (read_value !== want.rd || read_valid !== want.ok ||
              status !== want.st || length !== want.len) begin
            fail_count++;
            if (fail_count <= SHOWN_MAX)
              $display("%0t: mismatch: value %0d/%0d valid %0b/%0b status %0d/%0d len %0d/%0d",
                       $realtime, want.rd, read_value, want.ok, read_valid,
                       want.st, status, want.len, length);
          end
        end
      end
      if (in_valid && !in_stall) awaited.push_back(apply_command(command, position, value));
    end
    pending = awaited.size();
  end

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Stimulus, clock, reset and verdict for the indexed list store testbench.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ilst_pkg::*;

  localparam int unsigned CAPACITY    = CAPACITY_DEF;
  localparam int          RANDOM_CMDS = 1700;
  localparam int          CYCLE_LIMIT = 100000;
  localparam int          IDLE_PCT    = 14;
  localparam int          CMD_TOP     = (1 << CMD_W) - 1;

  // Activity profiles for the random commands.
  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } cmd_mix_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         command = CMD_READ;
  logic signed [POS_W-1:0]  position = '0;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] read_value;
  logic                     read_valid;
  logic [1:0]               status;
  logic [LEN_W-1:0]         length;
  int                       fail_count;
  int                       pending;
  int                       cycles = 0;
  logic                     calm = 1'b0;
  int                       len_hint = 0;

  indexed_list_store #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .read_valid(read_valid),
    .status(status), .length(length)
  );

  list_checker #(.CAPACITY(CAPACITY)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .position(position), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_value(read_value), .read_valid(read_valid),
    .status(status), .length(length),
    .fail_count(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Random back-pressure on the result side, none while calm.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Latest length seen, used only to aim positions at the live list.
  always @(posedge clk) begin
    if (out_valid && !out_stall) len_hint <= int'(length);
  end

  // Offer one command and hold it until the transfer; called at a falling edge.
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic signed [POS_W-1:0] pos,
                          logic signed [DATA_W-1:0] val);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off new commands until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_command(cmd_mix_t mix);
    int r;
    int t_read, t_head, t_tail, t_before, t_delete;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin t_read = 15; t_head = 35; t_tail = 60; t_before = 90; t_delete = 97; end
      MIX_DRAIN: begin t_read = 20; t_head = 28; t_tail = 36; t_before = 45; t_delete = 97; end
      default:   begin t_read = 30; t_head = 45; t_tail = 60; t_before = 75; t_delete = 97; end
    endcase
    if (r < t_read)   return CMD_READ;
    if (r < t_head)   return CMD_HEAD;
    if (r < t_tail)   return CMD_TAIL;
    if (r < t_before) return CMD_BEFORE;
    if (r < t_delete) return CMD_DELETE;
    return CMD_W'($urandom_range(int'(CMD_DELETE) + 1, CMD_TOP));
  endfunction

  // Mostly places inside or just past the list, sometimes anywhere.
  function automatic logic signed [POS_W-1:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return POS_W'($urandom_range(0, len_hint + 1));
    if (r < 95) return POS_W'($urandom_range(0, CAPACITY));
    return POS_W'($urandom);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(DATA_W-1){1'b1}}};
      1:       return {1'b1, {(DATA_W-1){1'b0}}};
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    cmd_mix_t mix;
    mix = MIX_FILL;

    // Reset is held and then released at a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty list, extreme values, clamping, bad places, undefined codes.
    send_cmd(CMD_READ, 8'sd0, '0);
    send_cmd(CMD_READ, -8'sd128, '0);
    send_cmd(CMD_DELETE, 8'sd0, '0);
    send_cmd(CMD_BEFORE, 8'sd1, 32'sd7);
    send_cmd(CMD_HEAD, 8'sd0, 32'h7FFF_FFFF);
    send_cmd(CMD_TAIL, 8'sd0, 32'h8000_0000);
    send_cmd(CMD_BEFORE, -8'sd128, 32'h0000_0000);
    send_cmd(CMD_BEFORE, 8'sd3, 32'hFFFF_FFFF);
    send_cmd(CMD_BEFORE, 8'sd2, 32'h5555_AAAA);
    send_cmd(CMD_BEFORE, 8'sd6, 32'h1234_5678);
    send_cmd(CMD_READ, 8'sd0, '1);
    send_cmd(CMD_READ, 8'sd4, '0);
    send_cmd(CMD_READ, 8'sd5, '0);
    send_cmd(CMD_READ, 8'sd127, '0);
    send_cmd(CMD_DELETE, 8'sd127, '0);
    send_cmd(CMD_DELETE, -8'sd1, '0);
    send_cmd(CMD_DELETE, 8'sd4, '0);
    send_cmd(CMD_DELETE, 8'sd0, '0);
    for (int c = int'(CMD_DELETE) + 1; c <= CMD_TOP; c++) send_cmd(CMD_W'(c), 8'sd1, '1);
    send_cmd(CMD_READ, 8'sd1, '0);
    drain_results();

    // Random: pick the fill, drain or even mix at random every 150 commands.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % 150 == 0) mix = cmd_mix_t'($urandom_range(0, 2));
      if (n % 400 == 399) drain_results();
      calm = (n >= 700 && n < 1000);
      send_cmd(pick_command(mix), pick_position(), pick_value());
    end
    calm = 1'b0;

    // Let the last results out, then a short settling time.
    drain_results();
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/ilst_pkg.sv
rtl/core/ilst_cell.sv
rtl/core/indexed_list_store.sv
sim/list_checker.sv
sim/tb_top.sv
